// ===== rtl/core/nppd_pkg.sv =====
// shared types and constants for the nearest projected point depth block
package nppd_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int DIV_W = 52;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;
    localparam logic [1:0] REQ_END = 2'd2;

    localparam logic [1:0] CFG_FOCAL_X = 2'd0;
    localparam logic [1:0] CFG_FOCAL_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_X = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y = 2'd3;

    localparam logic [63:0] FAR_LIMIT_SQ = 64'd25600000000000000;
    localparam logic [62:0] NEAR_LIMIT_SQ = 63'd256;
    localparam logic signed [31:0] HALF_METRE = 32'sd32768;

    typedef enum logic [1:0] {
        OP_BEGIN,
        OP_COUNT,
        OP_POINT,
        OP_END
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        query_u;
        logic [15:0]        query_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         point_red;
    } req_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic [15:0]        query_u;
        logic [15:0]        query_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } qent_t;

    typedef struct packed {
        logic [19:0] focal_x;
        logic [19:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } cfg_t;

endpackage

// ===== rtl/core/nppd_front.sv =====
// front end: takes requests and classifies them for the queue
module nppd_front (
    input  logic           req_valid,
    input  nppd_pkg::req_t req,
    input  logic           q_full,
    output logic           req_stall,
    output logic           q_push,
    output nppd_pkg::qent_t q_ent
);

    always_comb
    begin
        q_ent.query_u = req.query_u;
        q_ent.query_v = req.query_v;
        q_ent.point_x = req.point_x;
        q_ent.point_y = req.point_y;
        q_ent.point_z = req.point_z;
        q_ent.op = nppd_pkg::OP_BEGIN;
        q_push = 1'b0;
        case (req.req_type)
            nppd_pkg::REQ_BEGIN:
            begin
                q_ent.op = nppd_pkg::OP_BEGIN;
                q_push = req_valid && !q_full;
            end
            nppd_pkg::REQ_POINT:
            begin
                // bogus red or zero depth points are only counted
                if (req.point_red == 8'd0 || req.point_z == 32'sd0)
                    q_ent.op = nppd_pkg::OP_COUNT;
                else
                    q_ent.op = nppd_pkg::OP_POINT;
                q_push = req_valid && !q_full;
            end
            nppd_pkg::REQ_END:
            begin
                q_ent.op = nppd_pkg::OP_END;
                q_push = req_valid && !q_full;
            end
            default:
            begin
                // unused code: taken and dropped
                q_push = 1'b0;
            end
        endcase
    end

    assign req_stall = q_full;

endmodule

// ===== rtl/core/nppd_queue.sv =====
// small register queue between front and back
module nppd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nppd_pkg::qent_t wdata,
    input  logic            pop,
    output nppd_pkg::qent_t rdata,
    output logic            full,
    output logic            empty
);

    nppd_pkg::qent_t mem_reg [nppd_pkg::QDEPTH];
    logic [nppd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [nppd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [nppd_pkg::QPTR_W:0]   cnt_reg;

    assign full = (cnt_reg == (nppd_pkg::QPTR_W+1)'(nppd_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push && !full, pop && !empty})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/nppd_back.sv =====
// back end: projection, nearest search and ray scaling on a shared divider
module nppd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  nppd_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  nppd_pkg::qent_t q_ent,
    output logic            q_pop,
    input  logic            rsp_stall,
    output logic            rsp_valid,
    output nppd_pkg::rsp_t  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_POST,
        S_SQ,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [15:0]        held_u_reg;
    logic [15:0]        held_v_reg;
    logic signed [31:0] best_depth_reg;
    logic [63:0]        best_dsq_reg;
    logic [1:0]         tally_reg;
    logic               stopped_reg;

    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] depth_reg;
    logic               axis_reg;
    logic               is_end_reg;
    logic signed [52:0] prod_reg;
    logic               neg_reg;
    logic [31:0]        dvs_reg;
    logic [nppd_pkg::DIV_W-1:0] quo_reg;
    logic [32:0]        rem_reg;
    logic [nppd_pkg::DCNT_W-1:0] dcnt_reg;
    logic [30:0]        mag_reg;
    logic [62:0]        acc_reg;
    logic signed [31:0] rx_reg;
    logic               rsp_valid_reg;
    nppd_pkg::rsp_t     rsp_reg;

    logic signed [20:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [16:0] ray_off;
    logic [52:0]        prod_abs;
    logic [32:0]        rem_sh;
    logic signed [52:0] quo_s;
    logic signed [53:0] diff;
    logic [53:0]        diff_abs;
    logic [30:0]        mag_sat;
    logic signed [31:0] q_sat;
    logic signed [32:0] z_neg;
    logic               out_free;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        ray_off = $signed({1'b0, axis_reg ? held_v_reg : held_u_reg})
                - $signed({1'b0, axis_reg ? cfg.center_y : cfg.center_x});
        if (is_end_reg)
        begin
            mul_a = 21'(ray_off);
            mul_b = depth_reg;
        end
        else
        begin
            mul_a = $signed({1'b0, axis_reg ? cfg.focal_y : cfg.focal_x});
            mul_b = axis_reg ? py_reg : px_reg;
        end
        prod_abs = prod_reg[52] ? 53'(-prod_reg) : prod_reg;
        rem_sh = {rem_reg[31:0], quo_reg[nppd_pkg::DIV_W-1]};
        quo_s = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        diff = 54'(quo_s)
             + $signed({38'd0, axis_reg ? cfg.center_y : cfg.center_x})
             - $signed({38'd0, axis_reg ? held_v_reg : held_u_reg});
        diff_abs = diff[53] ? 54'(-diff) : diff;
        mag_sat = (diff_abs > 54'h7FFFFFFF) ? 31'h7FFFFFFF : diff_abs[30:0];
        if (quo_s > 53'sh7FFFFFFF)
            q_sat = 32'sh7FFFFFFF;
        else if (quo_s < -53'sh80000000)
            q_sat = 32'sh80000000;
        else
            q_sat = quo_s[31:0];
        z_neg = -33'(depth_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_u_reg <= '0;
            held_v_reg <= '0;
            best_depth_reg <= '0;
            best_dsq_reg <= '1;
            tally_reg <= '0;
            stopped_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        axis_reg <= 1'b0;
                        acc_reg <= '0;
                        case (q_ent.op)
                            nppd_pkg::OP_BEGIN:
                            begin
                                held_u_reg <= q_ent.query_u;
                                held_v_reg <= q_ent.query_v;
                                best_depth_reg <= '0;
                                best_dsq_reg <= '1;
                                tally_reg <= '0;
                                stopped_reg <= 1'b0;
                            end
                            nppd_pkg::OP_COUNT:
                            begin
                                if (!stopped_reg && tally_reg != 2'd2)
                                    tally_reg <= tally_reg + 1'b1;
                            end
                            nppd_pkg::OP_POINT:
                            begin
                                if (!stopped_reg)
                                begin
                                    if (tally_reg != 2'd2)
                                        tally_reg <= tally_reg + 1'b1;
                                    px_reg <= q_ent.point_x;
                                    py_reg <= q_ent.point_y;
                                    depth_reg <= q_ent.point_z;
                                    is_end_reg <= 1'b0;
                                    state_reg <= S_MUL;
                                end
                            end
                            nppd_pkg::OP_END:
                            begin
                                depth_reg <= (tally_reg == 2'd2) ? best_depth_reg
                                                                 : nppd_pkg::HALF_METRE;
                                is_end_reg <= 1'b1;
                                state_reg <= S_MUL;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    prod_reg <= 53'(mul_a * mul_b);
                    if (is_end_reg)
                    begin
                        // zero focal length divides by one
                        if ((axis_reg ? cfg.focal_y : cfg.focal_x) == 20'd0)
                            dvs_reg <= 32'd1;
                        else
                            dvs_reg <= {12'd0, axis_reg ? cfg.focal_y : cfg.focal_x};
                        neg_reg <= 1'b0;
                    end
                    else
                    begin
                        dvs_reg <= depth_reg[31] ? z_neg[31:0] : depth_reg;
                        neg_reg <= depth_reg[31];
                    end
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    quo_reg <= prod_abs[nppd_pkg::DIV_W-1:0];
                    neg_reg <= neg_reg ^ prod_reg[52];
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (rem_sh >= {1'b0, dvs_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, dvs_reg};
                        quo_reg <= {quo_reg[nppd_pkg::DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[nppd_pkg::DIV_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == nppd_pkg::DCNT_W'(nppd_pkg::DIV_W - 1))
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (is_end_reg)
                    begin
                        if (!axis_reg)
                        begin
                            rx_reg <= q_sat;
                            axis_reg <= 1'b1;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            py_reg <= q_sat;
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        mag_reg <= mag_sat;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    acc_reg <= acc_reg + 63'(mag_reg * mag_reg);
                    if (!axis_reg)
                    begin
                        axis_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if ({1'b0, acc_reg} < nppd_pkg::FAR_LIMIT_SQ
                        && {1'b0, acc_reg} < best_dsq_reg)
                    begin
                        best_depth_reg <= depth_reg;
                        best_dsq_reg <= {1'b0, acc_reg};
                    end
                    if (acc_reg < nppd_pkg::NEAR_LIMIT_SQ)
                        stopped_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.world_x <= rx_reg;
                        rsp_reg.world_y <= py_reg;
                        rsp_reg.world_z <= depth_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/nearest_projected_point_depth.sv =====
// top level of the nearest projected point depth block
// A begin request latches the query pixel (1/16 pixel units) and clears the
// search; each point request (Q16.16 metres) is counted and, unless its red
// byte or depth is zero, projected through the pinhole model and compared to
// the query by squared distance; the nearest point keeps its depth and a hit
// within one pixel freezes the search; an end request returns the query ray
// scaled to the kept depth, or to 0.5 m when fewer than two points came in.
// Requests enter a four-entry queue at one per cycle while it has room; the
// back end then takes them one at a time. Begin and counted-only points are
// handled in the idle state alone; a projected point runs multiply, prep,
// restoring divide, post and square steps for each axis and then a compare,
// and an end request runs multiply, prep, divide and post for each axis and
// then an emit step, all on the single shared one-bit-per-cycle divider. An
// end waits in its emit step only while the previous result still sits
// unaccepted. The result sits in an output register, so the back end keeps
// working while a result waits.
// Configuration is taken on any cycle with cfg_we and must only change while
// the block is idle.
module nearest_projected_point_depth (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  nppd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output nppd_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [19:0]    cfg_data
);

    nppd_pkg::cfg_t  cfg_reg;
    nppd_pkg::qent_t push_ent;
    nppd_pkg::qent_t head_ent;
    logic            q_push;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // configuration registers, reset to the default camera
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x <= 20'd9600;
            cfg_reg.focal_y <= 20'd9600;
            cfg_reg.center_x <= 16'd5120;
            cfg_reg.center_y <= 16'd3840;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nppd_pkg::CFG_FOCAL_X:  cfg_reg.focal_x <= cfg_data;
                nppd_pkg::CFG_FOCAL_Y:  cfg_reg.focal_y <= cfg_data;
                nppd_pkg::CFG_CENTER_X: cfg_reg.center_x <= cfg_data[15:0];
                nppd_pkg::CFG_CENTER_Y: cfg_reg.center_y <= cfg_data[15:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: classify and push
    nppd_front u_front (
        .req_valid (req_valid),
        .req       (req),
        .q_full    (q_full),
        .req_stall (req_stall),
        .q_push    (q_push),
        .q_ent     (push_ent)
    );

    // decoupling queue
    nppd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_ent),
        .pop   (q_pop),
        .rdata (head_ent),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: search state, arithmetic and result register
    nppd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_ent     (head_ent),
        .q_pop     (q_pop),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/nppd_checker.sv =====
// port-level checks for the nearest projected point depth block
module nppd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input nppd_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input nppd_pkg::rsp_t rsp
);

    // a stalled result stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result changed while stalled");

    // handshake outputs are always known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({req_stall, rsp_valid}))
        else $error("unknown handshake output");

endmodule

bind nearest_projected_point_depth nppd_checker u_nppd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== bench/testbench.sv =====
// self-checking testbench for the nearest projected point depth block
`timescale 1ns / 1ps

module testbench;

    // request code that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    // a projected point holds the back end through its divides, and up to
    // five requests can still sit in the queue and the back end
    localparam int SETTLE_CYCLES = 1000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    nppd_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    nppd_pkg::rsp_t rsp;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [19:0]    cfg_data;

    nearest_projected_point_depth DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // requests waiting to be driven and rays waiting to come back
    nppd_pkg::req_t pending_reqs[$];
    nppd_pkg::rsp_t expected_rays[$];

    // our copy of the camera setup
    logic [19:0] cam_fx, cam_fy;
    logic [15:0] cam_cx, cam_cy;

    // our copy of the search state
    logic [15:0]        track_qu, track_qv;
    logic signed [31:0] kept_depth;
    longint unsigned    kept_dist_sq;
    int                 seen_points;
    bit                 search_done;

    int  errors = 0;
    int  cycles = 0;
    int  reqs_accepted = 0;
    int  rays_checked = 0;
    int  rays_predicted = 0;
    int  long_hold = 0;       // set by the stimulus to start a long receiver hold-off
    bit  gaps_on = 1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // squared error along one axis of a point's projection, saturated
    function automatic longint unsigned axis_error(longint coord, longint focal,
                                                   longint center, longint query,
                                                   longint depth);
        longint proj;
        longint diff;
        longint unsigned mag;
        proj = (focal * coord) / depth + center;
        diff = proj - query;
        mag = diff < 0 ? longint'(-diff) : diff;
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag * mag;
    endfunction

    // one ray coordinate scaled to the given depth, saturated to 32 bits
    function automatic logic signed [31:0] ray_axis(logic [15:0] query, logic [15:0] center,
                                                    logic [19:0] focal, longint depth);
        longint offset;
        longint divisor;
        longint r;
        offset = longint'(query) - longint'(center);
        divisor = (focal == 0) ? 1 : longint'(focal);
        r = (offset * depth) / divisor;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic reset_search();
        kept_depth = 0;
        kept_dist_sq = 64'hFFFF_FFFF_FFFF_FFFF;
        seen_points = 0;
        search_done = 0;
    endtask

    // advance the search state for one accepted request, queue the ray on end
    task automatic track_request(nppd_pkg::req_t r);
        longint unsigned dsq;
        longint depth;
        nppd_pkg::rsp_t ray;
        case (r.req_type)
            nppd_pkg::REQ_BEGIN:
            begin
                track_qu = r.query_u;
                track_qv = r.query_v;
                reset_search();
            end
            nppd_pkg::REQ_POINT:
            begin
                if (!search_done)
                begin
                    if (seen_points < 2)
                        seen_points++;
                    // bogus red and zero depth points only count
                    if (r.point_red != 0 && r.point_z != 0)
                    begin
                        dsq = axis_error(longint'(r.point_x), longint'(cam_fx),
                                         longint'(cam_cx), longint'(track_qu),
                                         longint'(r.point_z))
                            + axis_error(longint'(r.point_y), longint'(cam_fy),
                                         longint'(cam_cy), longint'(track_qv),
                                         longint'(r.point_z));
                        if (dsq < nppd_pkg::FAR_LIMIT_SQ && dsq < kept_dist_sq)
                        begin
                            kept_depth = r.point_z;
                            kept_dist_sq = dsq;
                        end
                        if (dsq < 64'd256)
                            search_done = 1;
                    end
                end
            end
            nppd_pkg::REQ_END:
            begin
                depth = (seen_points >= 2) ? longint'(kept_depth)
                                           : longint'(nppd_pkg::HALF_METRE);
                ray.world_x = ray_axis(track_qu, cam_cx, cam_fx, depth);
                ray.world_y = ray_axis(track_qv, cam_cy, cam_fy, depth);
                ray.world_z = depth[31:0];
                expected_rays.push_back(ray);
                rays_predicted++;
            end
            default:
            begin
            end
        endcase
    endtask

    // gap after a request: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    // driver: presents queued requests, holds them while stalled
    int  gap_left = 0;
    nppd_pkg::req_t cur_req;
    always @(posedge clk)
    begin : driver
        bit busy;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            busy = req_valid;
            if (req_valid && !req_stall)
            begin
                track_request(cur_req);
                reqs_accepted++;
                busy = 0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req <= cur_req;
                    req_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks rays and drives the receiver stall
    int hold_left = 0;
    always @(posedge clk)
    begin : monitor
        nppd_pkg::rsp_t want;
        int roll;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rays.size() == 0)
                begin
                    $display("%0t: unexpected ray x=%0d y=%0d z=%0d", $time,
                             rsp.world_x, rsp.world_y, rsp.world_z);
                    errors++;
                end
                else
                begin
                    want = expected_rays.pop_front();
                    rays_checked++;
                    if (rsp.world_x !== want.world_x)
                    begin
                        $display("%0t: world_x expected %0d actual %0d", $time,
                                 want.world_x, rsp.world_x);
                        errors++;
                    end
                    if (rsp.world_y !== want.world_y)
                    begin
                        $display("%0t: world_y expected %0d actual %0d", $time,
                                 want.world_y, rsp.world_y);
                        errors++;
                    end
                    if (rsp.world_z !== want.world_z)
                    begin
                        $display("%0t: world_z expected %0d actual %0d", $time,
                                 want.world_z, rsp.world_z);
                        errors++;
                    end
                end
            end
            if (long_hold > 0)
            begin
                hold_left = long_hold;
                long_hold = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!gaps_on)
                rsp_stall <= 1'b0;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    rsp_stall <= 1'b0;
                else if (roll < 97)
                    rsp_stall <= 1'b1;
                else
                begin
                    rsp_stall <= 1'b1;
                    hold_left = $urandom_range(20, 300);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rays still expected", cycles,
                     expected_rays.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic nppd_pkg::req_t make_req(logic [1:0] kind, logic [15:0] qu,
                                                logic [15:0] qv,
                                                logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] z, logic [7:0] red);
        nppd_pkg::req_t r;
        r.req_type = kind;
        r.query_u = qu;
        r.query_v = qv;
        r.point_x = x;
        r.point_y = y;
        r.point_z = z;
        r.point_red = red;
        return r;
    endfunction

    function automatic nppd_pkg::req_t noise_req();
        nppd_pkg::req_t r;
        r.req_type = 2'($urandom_range(0, 3));
        r.query_u = 16'($urandom);
        r.query_v = 16'($urandom);
        r.point_x = $urandom;
        r.point_y = $urandom;
        r.point_z = $urandom;
        r.point_red = 8'($urandom);
        return r;
    endfunction

    // a plausible point in front of the camera, now and then with zero red, zero or negated depth
    function automatic nppd_pkg::req_t scene_point();
        nppd_pkg::req_t r;
        int roll;
        r = make_req(nppd_pkg::REQ_POINT, 16'($urandom), 16'($urandom),
                     $signed($urandom_range(0, 262144)) - 131072,
                     $signed($urandom_range(0, 262144)) - 131072,
                     $urandom_range(16384, 400000), 8'($urandom_range(1, 255)));
        roll = $urandom_range(0, 99);
        if (roll < 8)
            r.point_red = 0;
        else if (roll < 13)
            r.point_z = 0;
        else if (roll < 18)
            r.point_z = -r.point_z;
        return r;
    endfunction

    // a cloud: begin with a query near a point's projection if there is one, some points, an end
    task automatic queue_cloud(output int count);
        nppd_pkg::req_t pts[$];
        nppd_pkg::req_t p;
        longint u, v;
        int n;
        int roll;
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++)
        begin
            p = scene_point();
            pts.push_back(p);
        end
        if (n > 0 && pts[0].point_z != 0)
        begin
            u = (longint'(cam_fx) * longint'(pts[0].point_x)) / longint'(pts[0].point_z)
                + longint'(cam_cx) + $signed($urandom_range(0, 40)) - 20;
            v = (longint'(cam_fy) * longint'(pts[0].point_y)) / longint'(pts[0].point_z)
                + longint'(cam_cy) + $signed($urandom_range(0, 40)) - 20;
        end
        else
        begin
            u = $urandom;
            v = $urandom;
        end
        pending_reqs.push_back(make_req(nppd_pkg::REQ_BEGIN, u[15:0], v[15:0], $urandom,
                                        $urandom, $urandom, 8'($urandom)));
        foreach (pts[i])
            pending_reqs.push_back(pts[i]);
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 16'($urandom), 16'($urandom),
                                        $urandom, $urandom, $urandom, 8'($urandom)));
        count = n + 2;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            pending_reqs.push_back(noise_req());
            count++;
        end
        else if (roll < 20)
        begin
            // broken cloud: stray end with no new begin
            pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
            count++;
        end
    endtask

    // wait until everything queued has gone through and the back end is quiet
    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rays.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [19:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            nppd_pkg::CFG_FOCAL_X: cam_fx = value;
            nppd_pkg::CFG_FOCAL_Y: cam_fy = value;
            nppd_pkg::CFG_CENTER_X: cam_cx = value[15:0];
            default: cam_cy = value[15:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int budget);
        int used;
        int n;
        used = 0;
        while (used < budget)
        begin
            if ($urandom_range(0, 99) < 90)
                queue_cloud(n);
            else
            begin
                pending_reqs.push_back(noise_req());
                n = 1;
            end
            used += n;
            // keep the queue short so the stimulus follows the block
            while (pending_reqs.size() > 16)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nppd_pkg::CFG_FOCAL_X;
        cfg_data = '0;
        cam_fx = 20'd9600;
        cam_fy = 20'd9600;
        cam_cx = 16'd5120;
        cam_cy = 16'd3840;
        track_qu = 0;
        track_qv = 0;
        reset_search();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings
        // points before any begin use the reset query
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 32'sd65536, 32'sd0,
                                        32'sd65536, 8'd1));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, -32'sd65536, 32'sd0,
                                        32'sd131072, 8'd255));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
        // end repeated leaves the state alone
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        // unused code is ignored
        pending_reqs.push_back(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        // query at the principal point: zero depth, bogus red, exact hit, then frozen
        pending_reqs.push_back(make_req(nppd_pkg::REQ_BEGIN, 16'd5120, 16'd3840,
                                        0, 0, 0, 0));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 0, 0, 32'sd0, 8'd10));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 0, 0, 32'sd65536, 8'd0));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 0, 0, 32'sd98304, 8'd7));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 0, 0, 32'sd200000,
                                        8'd7));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
        // single point only: half metre
        pending_reqs.push_back(make_req(nppd_pkg::REQ_BEGIN, 16'd0, 16'hFFFF, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 0, 0, 32'sd65536, 8'd1));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
        // field extremes, no candidate survives: all zeros
        pending_reqs.push_back(make_req(nppd_pkg::REQ_BEGIN, 16'hFFFF, 16'd0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 32'sh7FFF_FFFF,
                                        32'sh8000_0000, 32'sd1, 8'hFF));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 32'sh8000_0000,
                                        32'sh7FFF_FFFF, -32'sd1, 8'h80));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
        // negative and largest depths
        pending_reqs.push_back(make_req(nppd_pkg::REQ_BEGIN, 16'd6000, 16'd3000,
                                        0, 0, 0, 0));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 32'sd1000, 32'sd1000,
                                        32'sh8000_0000, 8'd3));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_POINT, 0, 0, 32'sd1000, 32'sd1000,
                                        32'sh7FFF_FFFF, 8'd3));
        pending_reqs.push_back(make_req(nppd_pkg::REQ_END, 0, 0, 0, 0, 0, 0));
        drain();

        run_random(250);
        // hold the receiver off while the sender keeps offering clouds
        long_hold = 3000;
        run_random(60);
        drain();

        // extremes of focal length and center, then zero focal, then random setups
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(nppd_pkg::CFG_FOCAL_X, 20'd1);
                    write_reg(nppd_pkg::CFG_FOCAL_Y, 20'hFFFFF);
                    write_reg(nppd_pkg::CFG_CENTER_X, 20'd0);
                    write_reg(nppd_pkg::CFG_CENTER_Y, 20'hFFFF);
                end
                1:
                begin
                    write_reg(nppd_pkg::CFG_FOCAL_X, 20'hFFFFF);
                    write_reg(nppd_pkg::CFG_FOCAL_Y, 20'd1);
                    write_reg(nppd_pkg::CFG_CENTER_X, 20'hFFFF);
                    write_reg(nppd_pkg::CFG_CENTER_Y, 20'd0);
                end
                2:
                begin
                    write_reg(nppd_pkg::CFG_FOCAL_X, 20'd0);
                    write_reg(nppd_pkg::CFG_FOCAL_Y, 20'd0);
                end
                default:
                begin
                    write_reg(nppd_pkg::CFG_FOCAL_X, 20'($urandom_range(1, 20000)));
                    write_reg(nppd_pkg::CFG_FOCAL_Y, 20'($urandom_range(1, 1048575)));
                    write_reg(nppd_pkg::CFG_CENTER_X, 20'($urandom_range(0, 65535)));
                    write_reg(nppd_pkg::CFG_CENTER_Y, 20'($urandom_range(0, 65535)));
                end
            endcase
            // one phase runs without any idling
            gaps_on = (phase != 4);
            run_random(200);
            drain();
        end
        gaps_on = 1;

        // back to the reset values for a last stretch
        write_reg(nppd_pkg::CFG_FOCAL_X, 20'd9600);
        write_reg(nppd_pkg::CFG_FOCAL_Y, 20'd9600);
        write_reg(nppd_pkg::CFG_CENTER_X, 20'd5120);
        write_reg(nppd_pkg::CFG_CENTER_Y, 20'd3840);
        run_random(100);
        drain();

        $display("covered %0d requests over 9 camera setup stretches, %0d rays checked of %0d",
                 reqs_accepted, rays_checked, rays_predicted);
        $display("including field extremes, zero focal, long receiver hold-off, %0d errors",
                 errors);
        if (errors == 0 && expected_rays.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
